### src/zbr_pkg.sv
// ----------------------------------------------------------------------------
// zbr_pkg
// Shared types, op codes and constants for the z-buffered point/line raster.
// ----------------------------------------------------------------------------
package zbr_pkg;

   localparam int COORD_W  = 21;
   localparam int DEPTH_W  = 21;
   localparam int CHAR_W   = 8;
   localparam int BRIGHT_W = 16;
   localparam int FOCAL_W  = 18;
   localparam int CSR_W    = 18;
   localparam int CSR_IDX_W = 1;
   localparam int NUM_W    = 41;   // magnitude of projection numerator
   localparam int DEN_W    = 29;   // 512 * z for z < 2^20
   localparam int MAG_W    = 21;   // |b - a| per axis
   localparam int STEP_W   = 13;   // max |delta| / 256

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_POINT = 2'd1;
   localparam logic [1:0] OP_LINE  = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG    = 1'b1;

   localparam logic [FOCAL_W-1:0] FOCAL_RESET = 18'd51200;
   localparam logic [CHAR_W-1:0]  BG_RESET    = 8'd32;

   localparam logic [7:0] RAMP [0:22] = '{
      8'h20, 8'h2E, 8'h2C, 8'h3A, 8'h3B, 8'h69, 8'h72, 8'h73,
      8'h58, 8'h41, 8'h32, 8'h35, 8'h33, 8'h68, 8'h4D, 8'h48,
      8'h47, 8'h53, 8'h23, 8'h39, 8'h42, 8'h26, 8'h40};

   typedef struct packed {
      logic [1:0]                op;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] az;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic signed [COORD_W-1:0] bz;
      logic [CHAR_W-1:0]         ch;
      logic [7:0]                read_col;
      logic [7:0]                read_row;
   } item_type;

   typedef struct packed {
      logic init_busy;
      logic idle;
   } back_status_type;

   // brightness saturates at 255, ramp index = floor(b * 22 / 255)
   function automatic logic [CHAR_W-1:0] ramp_char(input logic [BRIGHT_W-1:0] br);
      logic [7:0]  b;
      logic [12:0] prod;
      logic [4:0]  idx;
      b    = (br > 16'd255) ? 8'hFF : br[7:0];
      prod = 13'(b) * 13'd22;
      idx  = '0;
      for (int k = 1; k <= 22; k++) begin
         if (prod >= 13'(255 * k)) idx = idx + 5'd1;
      end
      return RAMP[idx];
   endfunction

endpackage

### src/zbr_if.sv
// ----------------------------------------------------------------------------
// zbr_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface zbr_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         op;
   logic signed [zbr_pkg::COORD_W-1:0] ax;
   logic signed [zbr_pkg::COORD_W-1:0] ay;
   logic signed [zbr_pkg::COORD_W-1:0] az;
   logic signed [zbr_pkg::COORD_W-1:0] bx;
   logic signed [zbr_pkg::COORD_W-1:0] by;
   logic signed [zbr_pkg::COORD_W-1:0] bz;
   logic [zbr_pkg::BRIGHT_W-1:0]       brightness;
   logic [7:0]                         read_col;
   logic [7:0]                         read_row;

   modport source (output valid, op, ax, ay, az, bx, by, bz, brightness, read_col,
                   read_row, input ready);
   modport sink   (input valid, op, ax, ay, az, bx, by, bz, brightness, read_col,
                   read_row, output ready);
endinterface

interface zbr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [zbr_pkg::CHAR_W-1:0]         cell_char;
   logic signed [zbr_pkg::DEPTH_W-1:0] cell_depth;
   logic                               cell_empty;

   modport source (output valid, cell_char, cell_depth, cell_empty, input ready);
   modport sink   (input valid, cell_char, cell_depth, cell_empty, output ready);
endinterface

### src/zbr_ram.sv
// ----------------------------------------------------------------------------
// zbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module zbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

### src/zbr_div.sv
// ----------------------------------------------------------------------------
// zbr_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zbr_div #(
   parameter int NW = 41,
   parameter int DW = 29
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo,
   output logic [DW-1:0] rem
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [DW:0]   shifted, diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[NW-1]};
      diff    = shifted - {1'b0, den_ff};
      if (start) begin
         quo_in = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CW'(NW);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;
endmodule

### src/zbr_queue.sv
// ----------------------------------------------------------------------------
// zbr_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module zbr_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  zbr_pkg::item_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output zbr_pkg::item_type head
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   zbr_pkg::item_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (do_pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CW'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end
endmodule

### src/zbr_front.sv
// ----------------------------------------------------------------------------
// zbr_front
// Accepts requests, maps brightness to a ramp character, pushes to queue.
// ----------------------------------------------------------------------------
module zbr_front (
   zbr_req_if.sink                 req,
   input  zbr_pkg::back_status_type status,
   input  logic                    queue_full,
   output logic                    push,
   output zbr_pkg::item_type       push_data
);
   // no transfers while the frame store is being cleared after reset
   assign req.ready = !queue_full && !status.init_busy;
   assign push      = req.valid && req.ready;

   always_comb begin
      push_data.op       = req.op;
      push_data.ax       = req.ax;
      push_data.ay       = req.ay;
      push_data.az       = req.az;
      push_data.bx       = req.bx;
      push_data.by       = req.by;
      push_data.bz       = req.bz;
      push_data.ch       = zbr_pkg::ramp_char(req.brightness);
      push_data.read_col = req.read_col;
      push_data.read_row = req.read_row;
   end
endmodule

### src/zbr_back.sv
// ----------------------------------------------------------------------------
// zbr_back
// Sequencer: frame clear, line stepping, projection, z-test and cell read.
// ----------------------------------------------------------------------------
module zbr_back #(
   parameter int FRAME_WIDTH  = 120,
   parameter int FRAME_HEIGHT = 40
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  zbr_pkg::item_type              head,
   output logic                           pop,
   input  logic [zbr_pkg::FOCAL_W-1:0]    focal_length,
   input  logic [zbr_pkg::CHAR_W-1:0]     background_char,
   output zbr_pkg::back_status_type       status,
   zbr_rsp_if.source                      rsp
);
   localparam int CELLS  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW     = $clog2(CELLS);
   localparam int CXW    = $clog2(FRAME_WIDTH);
   localparam int CYW    = $clog2(FRAME_HEIGHT);
   localparam int DW     = zbr_pkg::DEPTH_W;
   localparam int CHW    = zbr_pkg::CHAR_W;
   localparam int WORD_W = CHW + 1 + DW;
   localparam int NW     = zbr_pkg::NUM_W;
   localparam int VW     = zbr_pkg::DEN_W;
   localparam int MW     = zbr_pkg::MAG_W;
   localparam int SW     = zbr_pkg::STEP_W;

   localparam logic [4:0] ST_SWEEP  = 5'd0;
   localparam logic [4:0] ST_IDLE   = 5'd1;
   localparam logic [4:0] ST_LSETUP = 5'd2;
   localparam logic [4:0] ST_LISSUE = 5'd3;
   localparam logic [4:0] ST_LDIV   = 5'd4;
   localparam logic [4:0] ST_LSTEP  = 5'd5;
   localparam logic [4:0] ST_PCHK   = 5'd6;
   localparam logic [4:0] ST_PMUL_X = 5'd7;
   localparam logic [4:0] ST_PSUM_X = 5'd8;
   localparam logic [4:0] ST_PDIV_X = 5'd9;
   localparam logic [4:0] ST_PMUL_Y = 5'd10;
   localparam logic [4:0] ST_PSUM_Y = 5'd11;
   localparam logic [4:0] ST_PDIV_Y = 5'd12;
   localparam logic [4:0] ST_PRD    = 5'd13;
   localparam logic [4:0] ST_PWR    = 5'd14;
   localparam logic [4:0] ST_RADDR  = 5'd15;
   localparam logic [4:0] ST_RDATA  = 5'd16;
   localparam logic [4:0] ST_DONE   = 5'd17;

   // control
   logic [4:0]    state_ff, state_in;
   logic          init_ff, init_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          dstart_ff, dstart_in;
   logic [1:0]    axis_ff, axis_in;

   // payload
   zbr_pkg::item_type    cur_ff, cur_in;
   logic [MW-1:0]        dmag_ff [3], dmag_in [3];
   logic                 dneg_ff [3], dneg_in [3];
   logic [MW-1:0]        incq_ff [3], incq_in [3];
   logic [SW-1:0]        incr_ff [3], incr_in [3];
   logic [MW-1:0]        accq_ff [3], accq_in [3];
   logic [SW-1:0]        accr_ff [3], accr_in [3];
   logic [SW-1:0]        step_ff, step_in, i_ff, i_in;
   logic signed [DW-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [39:0]   prod_ff, prod_in;
   logic                 nneg_ff, nneg_in;
   logic [NW-1:0]        dnum_ff, dnum_in;
   logic [VW-1:0]        dden_ff, dden_in;
   logic [CXW-1:0]       cx_ff, cx_in;
   logic [CYW-1:0]       cy_ff, cy_in;
   logic [CHW-1:0]       res_char_ff, res_char_in, out_char_ff, out_char_in;
   logic signed [DW-1:0] res_depth_ff, res_depth_in, out_depth_ff, out_depth_in;
   logic                 res_empty_ff, res_empty_in, out_empty_ff, out_empty_in;

   // datapath
   logic                 div_done;
   logic [NW-1:0]        div_quo;
   logic [VW-1:0]        div_rem;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr, ram_raddr, pt_idx, rd_idx;
   logic [WORD_W-1:0]    ram_wdata, ram_rdata;
   logic signed [DW-1:0] a_c [3], b_c [3];
   logic signed [DW:0]   dl [3];
   logic [MW-1:0]        dm [3];
   logic [MW-1:0]        mmax;
   logic [SW:0]          r_sum [3];
   logic [MW-1:0]        q_nx [3];
   logic [SW-1:0]        r_nx [3];
   logic signed [DW:0]   pt [3];
   logic signed [41:0]   nsum_x, nsum_y;
   logic [4:0]           ret_state;
   logic                 ok_x, ok_y, in_frame, z_pass;
   logic signed [DW-1:0] stored_z;

   zbr_div #(.NW(NW), .DW(VW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (dstart_ff),
      .num   (dnum_ff),
      .den   (dden_ff),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   zbr_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign a_c[0] = cur_ff.ax;
   assign a_c[1] = cur_ff.ay;
   assign a_c[2] = cur_ff.az;
   assign b_c[0] = cur_ff.bx;
   assign b_c[1] = cur_ff.by;
   assign b_c[2] = cur_ff.bz;

   // deltas, magnitudes and next interpolated point per axis
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dl[k]    = (DW+1)'(b_c[k]) - (DW+1)'(a_c[k]);
         dm[k]    = dl[k][DW] ? MW'(-dl[k]) : dl[k][MW-1:0];
         r_sum[k] = {1'b0, accr_ff[k]} + {1'b0, incr_ff[k]};
         if (r_sum[k] >= {1'b0, step_ff}) begin
            r_nx[k] = SW'(r_sum[k] - {1'b0, step_ff});
            q_nx[k] = accq_ff[k] + incq_ff[k] + MW'(1);
         end else begin
            r_nx[k] = r_sum[k][SW-1:0];
            q_nx[k] = accq_ff[k] + incq_ff[k];
         end
         pt[k] = dneg_ff[k] ? (DW+1)'(a_c[k]) - (DW+1)'({1'b0, q_nx[k]})
                            : (DW+1)'(a_c[k]) + (DW+1)'({1'b0, q_nx[k]});
      end
      mmax = dm[0];
      if (dm[1] > mmax) mmax = dm[1];
      if (dm[2] > mmax) mmax = dm[2];
   end

   // projection numerators: W*256*z + 4*f*x and H*128*z - f*y
   assign nsum_x = $signed(42'(FRAME_WIDTH * 256)) * 42'(pz_ff) + (42'(prod_ff) <<< 2);
   assign nsum_y = $signed(42'(FRAME_HEIGHT * 128)) * 42'(pz_ff) - 42'(prod_ff);

   // truncation toward zero: a negative numerator with zero quotient lands in cell 0
   assign ok_x = (!nneg_ff || div_quo == '0) && (div_quo < NW'(FRAME_WIDTH));
   assign ok_y = (!nneg_ff || div_quo == '0) && (div_quo < NW'(FRAME_HEIGHT));

   assign pt_idx   = AW'(cy_ff) * AW'(FRAME_WIDTH) + AW'(cx_ff);
   assign rd_idx   = AW'(cur_ff.read_row) * AW'(FRAME_WIDTH) + AW'(cur_ff.read_col);
   assign in_frame = (9'(cur_ff.read_col) < 9'(FRAME_WIDTH))
                  && (9'(cur_ff.read_row) < 9'(FRAME_HEIGHT));
   assign stored_z = ram_rdata[DW-1:0];
   assign z_pass   = ram_rdata[DW] || (pz_ff < stored_z);

   assign ret_state = (cur_ff.op == zbr_pkg::OP_LINE && i_ff != step_ff) ? ST_LSTEP : ST_DONE;

   assign ram_raddr = (state_ff == ST_RADDR) ? rd_idx : pt_idx;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = pt_idx;
      ram_wdata = {cur_ff.ch, 1'b0, pz_ff};
      if (state_ff == ST_SWEEP) begin
         ram_we    = 1'b1;
         ram_waddr = sweep_ff;
         ram_wdata = {background_char, 1'b1, {DW{1'b0}}};
      end else if (state_ff == ST_PWR) begin
         ram_we = z_pass;
      end
   end

   assign pop = (state_ff == ST_IDLE) && head_valid;

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      sweep_in     = sweep_ff;
      dstart_in    = 1'b0;
      axis_in      = axis_ff;
      cur_in       = cur_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      incq_in      = incq_ff;
      incr_in      = incr_ff;
      accq_in      = accq_ff;
      accr_in      = accr_ff;
      step_in      = step_ff;
      i_in         = i_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      prod_in      = prod_ff;
      nneg_in      = nneg_ff;
      dnum_in      = dnum_ff;
      dden_in      = dden_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      res_char_in  = res_char_ff;
      res_depth_in = res_depth_ff;
      res_empty_in = res_empty_ff;
      out_char_in  = out_char_ff;
      out_depth_in = out_depth_ff;
      out_empty_in = out_empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      unique case (state_ff)
         ST_SWEEP: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == AW'(CELLS - 1)) begin
               sweep_in = '0;
               init_in  = 1'b0;
               state_in = init_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               cur_in       = head;
               res_char_in  = '0;
               res_depth_in = '0;
               res_empty_in = 1'b0;
               px_in        = head.ax;
               py_in        = head.ay;
               pz_in        = head.az;
               unique case (head.op)
                  zbr_pkg::OP_CLEAR: state_in = ST_SWEEP;
                  zbr_pkg::OP_POINT: state_in = ST_PCHK;
                  zbr_pkg::OP_LINE:  state_in = ST_LSETUP;
                  zbr_pkg::OP_READ:  state_in = ST_RADDR;
                  default:           state_in = ST_DONE;
               endcase
            end
         end
         ST_LSETUP: begin
            for (int k = 0; k < 3; k++) begin
               dmag_in[k] = dm[k];
               dneg_in[k] = dl[k][DW];
            end
            step_in  = mmax[MW-1:8];
            axis_in  = '0;
            state_in = (mmax[MW-1:8] == '0) ? ST_DONE : ST_LISSUE;
         end
         ST_LISSUE: begin
            dnum_in   = NW'(dmag_ff[axis_ff]);
            dden_in   = VW'(step_ff);
            dstart_in = 1'b1;
            state_in  = ST_LDIV;
         end
         ST_LDIV: begin
            if (div_done) begin
               incq_in[axis_ff] = div_quo[MW-1:0];
               incr_in[axis_ff] = div_rem[SW-1:0];
               if (axis_ff == 2'd2) begin
                  for (int k = 0; k < 3; k++) begin
                     accq_in[k] = '0;
                     accr_in[k] = '0;
                  end
                  i_in     = '0;
                  state_in = ST_LSTEP;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_LISSUE;
               end
            end
         end
         ST_LSTEP: begin
            for (int k = 0; k < 3; k++) begin
               accq_in[k] = q_nx[k];
               accr_in[k] = r_nx[k];
            end
            i_in     = i_ff + SW'(1);
            px_in    = pt[0][DW-1:0];
            py_in    = pt[1][DW-1:0];
            pz_in    = pt[2][DW-1:0];
            state_in = ST_PCHK;
         end
         ST_PCHK: begin
            state_in = (pz_ff <= 0) ? ret_state : ST_PMUL_X;
         end
         ST_PMUL_X: begin
            prod_in  = $signed({1'b0, focal_length}) * px_ff;
            state_in = ST_PSUM_X;
         end
         ST_PSUM_X: begin
            nneg_in   = nsum_x[41];
            dnum_in   = nsum_x[41] ? NW'(-nsum_x) : nsum_x[NW-1:0];
            dden_in   = {pz_ff[DW-2:0], 9'd0};
            dstart_in = 1'b1;
            state_in  = ST_PDIV_X;
         end
         ST_PDIV_X: begin
            if (div_done) begin
               cx_in    = div_quo[CXW-1:0];
               state_in = ok_x ? ST_PMUL_Y : ret_state;
            end
         end
         ST_PMUL_Y: begin
            prod_in  = $signed({1'b0, focal_length}) * py_ff;
            state_in = ST_PSUM_Y;
         end
         ST_PSUM_Y: begin
            nneg_in   = nsum_y[41];
            dnum_in   = nsum_y[41] ? NW'(-nsum_y) : nsum_y[NW-1:0];
            dden_in   = {1'b0, pz_ff[DW-2:0], 8'd0};
            dstart_in = 1'b1;
            state_in  = ST_PDIV_Y;
         end
         ST_PDIV_Y: begin
            if (div_done) begin
               cy_in    = div_quo[CYW-1:0];
               state_in = ok_y ? ST_PRD : ret_state;
            end
         end
         ST_PRD: begin
            state_in = ST_PWR;
         end
         ST_PWR: begin
            state_in = ret_state;
         end
         ST_RADDR: begin
            if (in_frame) begin
               state_in = ST_RDATA;
            end else begin
               res_empty_in = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_RDATA: begin
            res_char_in = ram_rdata[WORD_W-1:DW+1];
            if (ram_rdata[DW]) begin
               res_empty_in = 1'b1;
            end else begin
               res_depth_in = stored_z;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_char_in  = res_char_ff;
               out_depth_in = res_depth_ff;
               out_empty_in = res_empty_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         init_ff      <= 1'b1;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dstart_ff    <= 1'b0;
         axis_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         dstart_ff    <= dstart_in;
         axis_ff      <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      dmag_ff      <= dmag_in;
      dneg_ff      <= dneg_in;
      incq_ff      <= incq_in;
      incr_ff      <= incr_in;
      accq_ff      <= accq_in;
      accr_ff      <= accr_in;
      step_ff      <= step_in;
      i_ff         <= i_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pz_ff        <= pz_in;
      prod_ff      <= prod_in;
      nneg_ff      <= nneg_in;
      dnum_ff      <= dnum_in;
      dden_ff      <= dden_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      res_char_ff  <= res_char_in;
      res_depth_ff <= res_depth_in;
      res_empty_ff <= res_empty_in;
      out_char_ff  <= out_char_in;
      out_depth_ff <= out_depth_in;
      out_empty_ff <= out_empty_in;
   end

   assign status.init_busy = init_ff;
   assign status.idle      = (state_ff == ST_IDLE);

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.cell_char  = out_char_ff;
   assign rsp.cell_depth = out_depth_ff;
   assign rsp.cell_empty = out_empty_ff;
endmodule

### src/zbuffer_point_line_raster.sv
// ----------------------------------------------------------------------------
// zbuffer_point_line_raster
// Z-buffered point and line rasterizer into a character frame.
// ----------------------------------------------------------------------------
// Usage:
//  req_ch carries one op per transfer: clear, point, line or read. Every op
//  returns exactly one rsp_ch transfer, in order; only read carries data,
//  the others return all-zero fields as a completion.
//  csr_* writes focal length (index 0) and background char (index 1); write
//  only while the block is idle.
//  A front stage takes requests and maps brightness to a ramp char, a
//  two-entry queue decouples it from the back sequencer, so a couple of
//  requests can be taken while the back is busy.
//  The back sequencer handles one op at a time:
//   clear : all W*H cells, one cell per cycle through the frame RAM port
//   point : up to two divides (x, then y) on the shared divider
//   line  : three divides in setup, then one point per drawn step
//   read  : at most one frame RAM read
//  Reset: the frame store is cleared by a pass over all W*H cells;
//  req_ch.ready stays low until that pass is done.
//  A stalled rsp_ch holds the result in the output register; the back waits
//  and the queue fills, after which req_ch.ready drops.
// ----------------------------------------------------------------------------
module zbuffer_point_line_raster #(
   parameter int FRAME_WIDTH  = 120,
   parameter int FRAME_HEIGHT = 40
) (
   input  logic                            clock,
   input  logic                            reset,
   zbr_req_if.sink                         req_ch,
   zbr_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [zbr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [zbr_pkg::CSR_W-1:0]       csr_wdata
);
   // configuration registers
   logic [zbr_pkg::FOCAL_W-1:0] focal_ff, focal_in;
   logic [zbr_pkg::CHAR_W-1:0]  bg_ff, bg_in;

   zbr_pkg::back_status_type status;
   zbr_pkg::item_type        push_data, head;
   logic                     push, queue_full, head_valid, pop;

   always_comb begin
      focal_in = focal_ff;
      bg_in    = bg_ff;
      if (csr_we) begin
         unique case (csr_index)
            zbr_pkg::CSR_FOCAL: focal_in = csr_wdata[zbr_pkg::FOCAL_W-1:0];
            zbr_pkg::CSR_BG:    bg_in    = csr_wdata[zbr_pkg::CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= zbr_pkg::FOCAL_RESET;
         bg_ff    <= zbr_pkg::BG_RESET;
      end else begin
         focal_ff <= focal_in;
         bg_ff    <= bg_in;
      end
   end

   // front: request transfer and classification
   zbr_front u_front (
      .req        (req_ch),
      .status     (status),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   zbr_queue #(.DEPTH(2)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // back: clear sweep, line walk, projection, z-test, read, result register
   zbr_back #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .focal_length    (focal_ff),
      .background_char (bg_ff),
      .status          (status),
      .rsp             (rsp_ch)
   );
endmodule

### src/zbr_checker.sv
// ----------------------------------------------------------------------------
// zbr_checker
// Port-level checks on the raster block, bound to the top level.
// ----------------------------------------------------------------------------
module zbr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [zbr_pkg::CHAR_W-1:0]         rsp_char,
   input logic signed [zbr_pkg::DEPTH_W-1:0] rsp_depth,
   input logic                               rsp_empty
);
   // frame clear after reset blocks requests
   a_init_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during reset clear pass");

   a_no_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an empty cell never reports a depth
   a_empty_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty |-> rsp_depth == 0)
      else $error("empty cell with nonzero depth");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char)
         && $stable(rsp_depth) && $stable(rsp_empty))
      else $error("response changed while stalled");
endmodule

bind zbuffer_point_line_raster zbr_checker u_zbr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_char  (rsp_ch.cell_char),
   .rsp_depth (rsp_ch.cell_depth),
   .rsp_empty (rsp_ch.cell_empty)
);

### bench/zbuffer_point_line_raster_tb.sv
// ----------------------------------------------------------------------------
// zbuffer_point_line_raster_tb
// Self-checking bench for the z-buffered point/line raster: a frame and z-buffer
// shadow predicts every response, and random traffic runs under varied stalls.
// ----------------------------------------------------------------------------
module zbuffer_point_line_raster_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = 120;
   localparam int H = 40;
   localparam int CELLS = W * H;
   // idle cycles before the run is abandoned; sized to outlast a full-length
   // line of 8191 drawn steps
   localparam int STALL_LIMIT = 3000000;
   localparam string RAMP_STR = " .,:;irsXA253hMHGS#9B&@";

   typedef struct {
      logic [1:0]         op;
      logic signed [20:0] ax, ay, az, bx, by, bz;
      logic [15:0]        brightness;
      logic [7:0]         read_col, read_row;
   } raster_op_type;

   typedef struct {
      logic [7:0]         cell_char;
      logic signed [20:0] cell_depth;
      logic               cell_empty;
   } cell_rd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [zbr_pkg::CSR_IDX_W-1:0] csr_index = zbr_pkg::CSR_FOCAL;
   logic [zbr_pkg::CSR_W-1:0] csr_wdata = '0;

   zbr_req_if req_if ();
   zbr_rsp_if rsp_if ();

   zbuffer_point_line_raster #(.FRAME_WIDTH(W), .FRAME_HEIGHT(H)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_if.sink),
      .rsp_ch   (rsp_if.source),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // frame shadow: characters, 22-bit depth (bit 21 = infinity)
   logic [7:0]  frame_chars [CELLS];
   logic [21:0] frame_depth [CELLS];
   logic [17:0] focal_q = zbr_pkg::FOCAL_RESET;
   logic [7:0]  bg_q = zbr_pkg::BG_RESET;
   cell_rd_type pending_cells [$];

   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;
   int last_col = 0, last_row = 0;
   logic signed [20:0] last_z = 21'sd2560;

   initial begin
      req_if.valid = 1'b0;
      req_if.op = zbr_pkg::OP_READ;
      req_if.ax = '0; req_if.ay = '0; req_if.az = '0;
      req_if.bx = '0; req_if.by = '0; req_if.bz = '0;
      req_if.brightness = '0;
      req_if.read_col = '0; req_if.read_row = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic void wipe_frame();
      for (int i = 0; i < CELLS; i++) begin
         frame_chars[i] = bg_q;
         frame_depth[i] = 22'h200000;
      end
   endfunction

   function automatic logic [7:0] shade_of(logic [15:0] br);
      int b;
      b = (br > 16'd255) ? 255 : int'(br);
      return RAMP_STR[(b * 22) / 255];
   endfunction

   // perspective project, clip and z-test one point
   function automatic void plot_point(longint px, longint py, longint pz, logic [7:0] ch);
      longint f, cx, cy;
      int idx;
      f = longint'(focal_q);
      if (pz <= 0) return;
      cx = (longint'(W) * 256 * pz + 4 * f * px) / (512 * pz);
      cy = (longint'(H) * 128 * pz - f * py) / (256 * pz);
      if (cx < 0 || cy < 0 || cx >= W || cy >= H) return;
      last_col = int'(cx);
      last_row = int'(cy);
      idx = int'(cy) * W + int'(cx);
      if (frame_depth[idx][21] || pz < longint'(frame_depth[idx][20:0])) begin
         frame_chars[idx] = ch;
         frame_depth[idx] = {1'b0, 21'(pz)};
      end
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // apply one accepted op to the shadow and return its response
   function automatic cell_rd_type raster_apply(raster_op_type r);
      cell_rd_type res;
      logic [7:0] ch;
      longint dx, dy, dz, m, steps;
      int idx;
      res = '{cell_char: 8'd0, cell_depth: 21'sd0, cell_empty: 1'b0};
      ch = shade_of(r.brightness);
      case (r.op)
         zbr_pkg::OP_CLEAR: wipe_frame();
         zbr_pkg::OP_POINT: plot_point(r.ax, r.ay, r.az, ch);
         zbr_pkg::OP_LINE: begin
            dx = longint'(r.bx) - r.ax;
            dy = longint'(r.by) - r.ay;
            dz = longint'(r.bz) - r.az;
            m = magnitude(dx);
            if (magnitude(dy) > m) m = magnitude(dy);
            if (magnitude(dz) > m) m = magnitude(dz);
            steps = m / 256;
            for (longint i = 1; i <= steps; i++)
               plot_point(r.ax + dx * i / steps, r.ay + dy * i / steps,
                          r.az + dz * i / steps, ch);
         end
         default: begin
            if (r.read_col < W && r.read_row < H) begin
               idx = int'(r.read_row) * W + int'(r.read_col);
               res.cell_char = frame_chars[idx];
               if (frame_depth[idx][21]) res.cell_empty = 1'b1;
               else res.cell_depth = frame_depth[idx][20:0];
            end else begin
               res.cell_empty = 1'b1;
            end
         end
      endcase
      return res;
   endfunction

   // drive one op; the shadow is updated at the transfer edge
   task automatic send_op(raster_op_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op <= r.op;
      req_if.ax <= r.ax; req_if.ay <= r.ay; req_if.az <= r.az;
      req_if.bx <= r.bx; req_if.by <= r.by; req_if.bz <= r.bz;
      req_if.brightness <= r.brightness;
      req_if.read_col <= r.read_col;
      req_if.read_row <= r.read_row;
      do @(posedge clock); while (!req_if.ready);
      pending_cells.push_back(raster_apply(r));
   endtask

   task automatic hold_valid_low();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // both registers, back to back, only while idle
   task automatic write_csrs(logic [17:0] focal, logic [7:0] bg);
      csr_we <= 1'b1;
      csr_index <= zbr_pkg::CSR_FOCAL;
      csr_wdata <= focal;
      @(posedge clock);
      focal_q = focal;
      csr_index <= zbr_pkg::CSR_BG;
      csr_wdata <= zbr_pkg::CSR_W'(bg);
      @(posedge clock);
      bg_q = bg;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic raster_op_type noise_op(logic [1:0] op);
      raster_op_type r;
      r.op = op;
      r.ax = 21'($urandom); r.ay = 21'($urandom); r.az = 21'($urandom);
      r.bx = 21'($urandom); r.by = 21'($urandom); r.bz = 21'($urandom);
      r.brightness = 16'($urandom);
      r.read_col = 8'($urandom); r.read_row = 8'($urandom);
      return r;
   endfunction

   function automatic raster_op_type point_op(longint x, longint y, longint z, int br);
      raster_op_type r;
      r = noise_op(zbr_pkg::OP_POINT);
      r.ax = 21'(x); r.ay = 21'(y); r.az = 21'(z);
      r.brightness = 16'(br);
      return r;
   endfunction

   function automatic raster_op_type read_op(int col, int row);
      raster_op_type r;
      r = noise_op(zbr_pkg::OP_READ);
      r.read_col = 8'(col);
      r.read_row = 8'(row);
      return r;
   endfunction

   // a point that mostly lands in the frame at the default focal length
   function automatic raster_op_type visible_point();
      raster_op_type r;
      int z;
      z = ($urandom_range(9) == 0) ? int'(last_z) : int'($urandom_range(512, 15360));
      r = point_op($signed($urandom_range(0, z / 3)) - z / 6,
                   $signed($urandom_range(0, z / 5)) - z / 10, z,
                   ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(255));
      last_z = 21'(z);
      return r;
   endfunction

   // mostly short lines around visible points, a few longer ones
   function automatic raster_op_type visible_line();
      raster_op_type r;
      int span;
      r = visible_point();
      r.op = zbr_pkg::OP_LINE;
      span = ($urandom_range(15) == 0) ? 256 * 50 : 256 * 12;
      r.bx = r.ax + 21'($signed($urandom_range(0, 2 * span)) - span);
      r.by = r.ay + 21'($signed($urandom_range(0, 2 * span)) - span);
      r.bz = r.az + 21'($signed($urandom_range(0, span)) - span / 4);
      return r;
   endfunction

   function automatic raster_op_type random_op();
      int sel;
      sel = $urandom_range(199);
      if (sel < 2) return noise_op(zbr_pkg::OP_CLEAR);
      if (sel < 20) return noise_op(2'($urandom_range(1, 3)));  // random fields, mostly off frame
      if (sel < 100) return visible_point();
      if (sel < 130) return visible_line();
      if (sel < 165) return read_op(last_col, last_row);
      return read_op($urandom_range(W - 1), $urandom_range(H - 1));
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      raster_op_type r;
      send_op(read_op(0, 0));
      send_op(read_op(W - 1, H - 1));
      send_op(read_op(W, 0));          // just outside
      send_op(read_op(0, H));
      send_op(read_op(255, 255));
      send_op(point_op(0, 0, 2560, 0));
      send_op(read_op(W / 2, H / 2));
      send_op(point_op(0, 0, 2560, 65535));   // depth tie: no draw
      send_op(point_op(0, 0, 2559, 255));     // nearer: draws
      send_op(point_op(0, 0, 9000, 200));     // farther: no draw
      send_op(read_op(W / 2, H / 2));
      send_op(point_op(0, 0, 0, 100));        // depth zero dropped
      send_op(point_op(0, 0, -1048576, 100)); // negative depth dropped
      send_op(point_op(1048575, 0, 256, 100)); // off frame
      send_op(point_op(-1048576, -1048576, 1048575, 128));
      send_op(point_op(1048575, 1048575, 1048575, 128));
      r = point_op(100, 100, 3000, 255);
      r.op = zbr_pkg::OP_LINE; r.bx = 300; r.by = 300; r.bz = 3100;     // step zero
      send_op(r);
      r = point_op(-2560, 0, 4000, 170);
      r.op = zbr_pkg::OP_LINE; r.bx = 2560; r.by = 1280; r.bz = 4000;   // 20 steps
      send_op(r);
      send_op(read_op(last_col, last_row));
      send_op(noise_op(zbr_pkg::OP_CLEAR));
      send_op(read_op(last_col, last_row));
      hold_valid_low();
   endtask

   task automatic test_config_extremes();
      wait_drained();
      write_csrs(18'h3FFFF, 8'd255);
      send_op(noise_op(zbr_pkg::OP_CLEAR));
      repeat (8) send_op(visible_point());
      send_op(read_op(last_col, last_row));
      send_op(read_op(3, 3));
      hold_valid_low();
      wait_drained();
      write_csrs(18'd0, 8'd0);   // zero focal: everything lands in the center cell
      send_op(noise_op(zbr_pkg::OP_CLEAR));
      repeat (4) send_op(visible_point());
      send_op(read_op(W / 2, H / 2));
      send_op(read_op(1, 1));
      hold_valid_low();
      wait_drained();
      write_csrs(zbr_pkg::FOCAL_RESET, zbr_pkg::BG_RESET);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 65 : 0;
         recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 12 : 0;
         repeat (130) send_op(random_op());
         hold_valid_low();
         wait_drained();
         write_csrs(18'($urandom_range(25600, 76800)), 8'($urandom_range(33, 126)));
      end
      write_csrs(zbr_pkg::FOCAL_RESET, zbr_pkg::BG_RESET);
   endtask

   task automatic test_backpressure();
      hold_cycles = 500;             // receiver stalls, the input queue backs up
      repeat (12) send_op(read_op($urandom_range(W - 1), $urandom_range(H - 1)));
      hold_valid_low();
      wait_drained();                // sender pauses until everything is back
      repeat (6) send_op(visible_point());
      send_op(read_op(last_col, last_row));
      hold_valid_low();
   endtask

   // ----------------------------------------------------------- response check
   always @(posedge clock) begin : rsp_check
      cell_rd_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_cells.size() == 0) begin
            $error("response transfer with nothing outstanding");
            errors++;
         end else begin
            want = pending_cells.pop_front();
            if (rsp_if.cell_char !== want.cell_char) begin
               $error("cell_char expected %0h actual %0h", want.cell_char, rsp_if.cell_char);
               errors++;
            end
            if (rsp_if.cell_depth !== want.cell_depth) begin
               $error("cell_depth expected %0d actual %0d", want.cell_depth,
                      rsp_if.cell_depth);
               errors++;
            end
            if (rsp_if.cell_empty !== want.cell_empty) begin
               $error("cell_empty expected %0b actual %0b", want.cell_empty,
                      rsp_if.cell_empty);
               errors++;
            end
         end
      end
      // receiver stall: long hold-off first, else random idling
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: consecutive cycles without any transfer
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      wipe_frame();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_random_traffic();
      test_backpressure();
      wait_drained();
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_cells.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
src/zbr_pkg.sv
src/zbr_if.sv
src/zbr_ram.sv
src/zbr_div.sv
src/zbr_queue.sv
src/zbr_front.sv
src/zbr_back.sv
src/zbuffer_point_line_raster.sv
src/zbr_checker.sv
bench/zbuffer_point_line_raster_tb.sv
